// ===== design/rsrg_pkg.sv =====
package rsrg_pkg;

	localparam int HeapDepth = 16;
	localparam int IdxW = $clog2(HeapDepth);
	localparam int CntW = $clog2(HeapDepth + 1);
	localparam int CapW = 5;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_res;
		logic               run_start;
		logic               stream_end;
		logic               burst_last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic pop;
		logic sink_step;
		logic push_write;
		logic sift_step;
		logic clear_emitted;
	} rsrg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_pop;
		logic empty;
		logic sink_done;
		logic sift_done;
		logic last_item;
		logic pop_last;
	} rsrg_sts_t;

endpackage

// ===== design/rsrg_datapath.sv =====
module rsrg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsrg_pkg::in_item_t         in_item,
	input  logic [rsrg_pkg::CapW-1:0]  cap_cfg,
	input  rsrg_pkg::rsrg_cmd_t        cmd,
	output rsrg_pkg::rsrg_sts_t        sts,
	output logic signed [31:0]         pop_key,
	output logic                       pop_start
);
	import rsrg_pkg::*;

	logic signed [31:0] keys_q [HeapDepth];
	logic               tags_q [HeapDepth];
	logic [CntW-1:0]    count_q;
	logic signed [31:0] last_q;
	logic               cur_tag_q;
	logic               emitted_q;
	in_item_t           item_q;
	logic [IdxW-1:0]    pos_q;

	logic [CntW-1:0] cap_eff;
	logic [CntW:0]   l_w, r_w, p_w;
	logic [IdxW-1:0] l_i, r_i, m_i, p_i;
	logic            l_ok, r_ok, m_is_l, m_is_r;
	logic            new_tag;

	// order entry a before b: current run first, then key
	function automatic logic precedes(logic ta, logic signed [31:0] ka,
			logic tb, logic signed [31:0] kb, logic cur);
		logic ra, rb;
		ra = (ta != cur);
		rb = (tb != cur);
		if (ra != rb) return rb;
		return ka < kb;
	endfunction

	// clamp capacity to one through depth
	always_comb begin
		if (cap_cfg == '0) cap_eff = CntW'(1);
		else if ({1'b0, cap_cfg} > (CapW+1)'(HeapDepth)) cap_eff = CntW'(HeapDepth);
		else cap_eff = CntW'(cap_cfg);
	end

	// one sift-down level: pick smallest of node and children
	always_comb begin
		l_w  = ((CntW+1)'(pos_q) << 1) + (CntW+1)'(1);
		r_w  = ((CntW+1)'(pos_q) << 1) + (CntW+1)'(2);
		l_i  = l_w[IdxW-1:0];
		r_i  = r_w[IdxW-1:0];
		l_ok = l_w < {1'b0, count_q};
		r_ok = r_w < {1'b0, count_q};
		m_i  = pos_q;
		m_is_l = 1'b0;
		m_is_r = 1'b0;
		if (l_ok && precedes(tags_q[l_i], keys_q[l_i], tags_q[pos_q], keys_q[pos_q],
				cur_tag_q)) begin
			m_i = l_i;
			m_is_l = 1'b1;
		end
		if (r_ok && precedes(tags_q[r_i], keys_q[r_i], tags_q[m_i], keys_q[m_i],
				cur_tag_q)) begin
			m_i = r_i;
			m_is_r = 1'b1;
		end
	end

	// one sift-up level
	always_comb begin
		p_w = ((CntW+1)'(pos_q) - (CntW+1)'(1)) >> 1;
		p_i = p_w[IdxW-1:0];
	end

	assign new_tag = (emitted_q && item_q.value < last_q) ? ~cur_tag_q : cur_tag_q;

	assign sts.need_pop  = (count_q >= cap_eff) && (count_q != '0);
	assign sts.empty     = (count_q == '0);
	assign sts.sink_done = !(m_is_l || m_is_r);
	assign sts.sift_done = (pos_q == '0) ||
		!precedes(tags_q[pos_q], keys_q[pos_q], tags_q[p_i], keys_q[p_i], cur_tag_q);
	assign sts.last_item = item_q.last_item;
	assign sts.pop_last  = (count_q == CntW'(1));

	assign pop_key   = keys_q[0];
	assign pop_start = !emitted_q || (tags_q[0] != cur_tag_q);

	// heap store: no reset, only entries below the count are read
	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= in_item;
		if (cmd.pop) begin
			keys_q[0] <= keys_q[IdxW'(count_q - CntW'(1))];
			tags_q[0] <= tags_q[IdxW'(count_q - CntW'(1))];
		end
		if (cmd.sink_step && (m_is_l || m_is_r)) begin
			keys_q[pos_q] <= keys_q[m_i];
			tags_q[pos_q] <= tags_q[m_i];
			keys_q[m_i]   <= keys_q[pos_q];
			tags_q[m_i]   <= tags_q[pos_q];
		end
		if (cmd.push_write) begin
			keys_q[IdxW'(count_q)] <= item_q.value;
			tags_q[IdxW'(count_q)] <= new_tag;
		end
		if (cmd.sift_step && !sts.sift_done) begin
			keys_q[pos_q] <= keys_q[p_i];
			tags_q[pos_q] <= tags_q[p_i];
			keys_q[p_i]   <= keys_q[pos_q];
			tags_q[p_i]   <= tags_q[pos_q];
		end
	end

	// count, run state, walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			last_q    <= '0;
			cur_tag_q <= 1'b0;
			emitted_q <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (cmd.pop) begin
				cur_tag_q <= tags_q[0];
				last_q    <= keys_q[0];
				emitted_q <= 1'b1;
				count_q   <= count_q - CntW'(1);
				pos_q     <= '0;
			end
			if (cmd.sink_step) pos_q <= m_i;
			if (cmd.push_write) begin
				count_q <= count_q + CntW'(1);
				pos_q   <= IdxW'(count_q);
			end
			if (cmd.sift_step) pos_q <= p_i;
			if (cmd.clear_emitted) emitted_q <= 1'b0;
		end
	end

endmodule

// ===== design/rsrg_ctrl.sv =====
module rsrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output rsrg_pkg::rsrg_cmd_t cmd,
	input  rsrg_pkg::rsrg_sts_t sts,
	input  logic signed [31:0]  pop_key,
	input  logic                pop_start,
	output rsrg_pkg::out_item_t out_item
);
	import rsrg_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_SINK, S_PUSH, S_SIFT, S_DRAIN, S_DSINK
	} state_t;

	state_t    state_q;
	logic      out_valid_q;
	out_item_t out_q;
	logic      can_emit;

	assign can_emit  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// issue datapath commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.load_in = in_valid;
			S_DECIDE: cmd.pop = sts.need_pop && can_emit;
			S_SINK:   cmd.sink_step = 1'b1;
			S_PUSH:   cmd.push_write = 1'b1;
			S_SIFT:   cmd.sift_step = 1'b1;
			S_DRAIN: begin
				cmd.pop = !sts.empty && can_emit;
				cmd.clear_emitted = sts.empty;
			end
			S_DSINK:  cmd.sink_step = 1'b1;
			default:  cmd = '0;
		endcase
	end

	// sequence one item and hold the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cmd.pop) begin
				out_valid_q       <= 1'b1;
				out_q.value_res   <= pop_key;
				out_q.run_start   <= pop_start;
				out_q.stream_end  <= (state_q == S_DRAIN) && sts.pop_last;
				out_q.burst_last  <= (state_q == S_DRAIN) ? sts.pop_last
					: !sts.last_item;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (!sts.need_pop) state_q <= S_PUSH;
					else if (can_emit) state_q <= S_SINK;
				end
				S_SINK:   if (sts.sink_done) state_q <= S_PUSH;
				S_PUSH:   state_q <= S_SIFT;
				S_SIFT:   if (sts.sift_done)
					state_q <= sts.last_item ? S_DRAIN : S_IDLE;
				S_DRAIN: begin
					if (sts.empty) state_q <= S_IDLE;
					else if (can_emit) state_q <= S_DSINK;
				end
				S_DSINK:  if (sts.sink_done) state_q <= S_DRAIN;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/replacement_selection_run_generator_top.sv =====
// Replacement-selection run generator: signed keys enter a min-heap of up to
// heap_capacity entries (register, 1..16, reset 16); once full, each item pops
// and emits the smallest current-run key, then inserts the new key, tagging it
// for the next run when it is below the key just emitted. run_start flags the
// first key of each run; an item with last_item set drains the heap, the final
// key carrying stream_end. burst_last marks the last beat caused by an item.
// The input stalls until an item is done; a pop walks one heap level per cycle
// down, the insert one level per cycle up; a drain adds one pop walk per entry.
// Write the capacity only while the block is idle.
module replacement_selection_run_generator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rsrg_pkg::in_item_t        in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rsrg_pkg::out_item_t       out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rsrg_pkg::CapW-1:0] cfg_data
);
	import rsrg_pkg::*;

	rsrg_cmd_t          cmd;
	rsrg_sts_t          sts;
	logic signed [31:0] pop_key;
	logic               pop_start;
	logic [CapW-1:0]    cap_q;

	assign cfg_ready = 1'b1;

	// hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CapW'(HeapDepth);
		else if (cfg_valid) cap_q <= cfg_data;
	end

	rsrg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts),
		.pop_key(pop_key), .pop_start(pop_start), .out_item(out_data)
	);

	rsrg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cap_cfg(cap_q),
		.cmd(cmd), .sts(sts), .pop_key(pop_key), .pop_start(pop_start)
	);

endmodule

// ===== design/rsrg_checker.sv =====
module rsrg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input rsrg_pkg::out_item_t out_data
);
	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	// stream end closes the burst
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stream_end |-> out_data.burst_last)
		else $error("stream_end without burst_last");

	// an accepted item stalls the input in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

	// stream end starts a fresh stream; no beat comes straight after the accepted end beat
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.stream_end |=> !out_valid)
		else $error("beat right after stream end");

endmodule

bind replacement_selection_run_generator_top rsrg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== sim/replacement_selection_run_generator_top_tb.sv =====
`timescale 1ns / 1ps

module replacement_selection_run_generator_top_tb;
	import rsrg_pkg::*;

	localparam int CapMax = 16;
	localparam int DrainWait = 400;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [4:0] cfg_data;

	replacement_selection_run_generator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// sorter shadow state
	logic signed [31:0] shadow_keys [CapMax];
	logic               shadow_tags [CapMax];
	int                 shadow_count;
	logic signed [31:0] shadow_last_key;
	logic               shadow_run_tag;
	logic               shadow_emitted;
	logic [4:0]         shadow_capacity;

	out_item_t pending_keys [$];
	int        error_count;
	int        item_count;
	int        key_count;
	int        run_count;
	int        stream_count;
	bit        hold_sink;
	bit        sink_noise;

	always #5 clk = ~clk;

	function automatic bit entry_first(int a, int b);
		bit ra;
		bit rb;
		ra = shadow_tags[a] != shadow_run_tag;
		rb = shadow_tags[b] != shadow_run_tag;
		if (ra != rb)
			return ra < rb;
		return shadow_keys[a] < shadow_keys[b];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic signed [31:0] k;
		logic               t;
		k = shadow_keys[a];
		t = shadow_tags[a];
		shadow_keys[a] = shadow_keys[b];
		shadow_tags[a] = shadow_tags[b];
		shadow_keys[b] = k;
		shadow_tags[b] = t;
	endfunction

	function automatic void heap_insert(logic signed [31:0] key, logic tag);
		int i;
		int p;
		if (shadow_count >= CapMax)
			return;
		i = shadow_count;
		shadow_count++;
		shadow_keys[i] = key;
		shadow_tags[i] = tag;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!entry_first(i, p))
				break;
			swap_slots(i, p);
			i = p;
		end
	endfunction

	function automatic out_item_t heap_pop();
		out_item_t r;
		int i;
		int l;
		int m;
		r = '0;
		r.value_res = shadow_keys[0];
		r.run_start = !shadow_emitted || shadow_tags[0] != shadow_run_tag;
		shadow_run_tag = shadow_tags[0];
		shadow_count--;
		if (shadow_count > 0) begin
			shadow_keys[0] = shadow_keys[shadow_count];
			shadow_tags[0] = shadow_tags[shadow_count];
			i = 0;
			forever begin
				l = 2 * i + 1;
				m = i;
				if (l < shadow_count && entry_first(l, m))
					m = l;
				if (l + 1 < shadow_count && entry_first(l + 1, m))
					m = l + 1;
				if (m == i)
					break;
				swap_slots(i, m);
				i = m;
			end
		end
		shadow_last_key = r.value_res;
		shadow_emitted = 1'b1;
		if (r.run_start)
			run_count++;
		return r;
	endfunction

	// work out the keys one accepted item releases
	function automatic void sort_step(in_item_t it);
		out_item_t burst [$];
		int cap;
		logic tag;
		cap = shadow_capacity;
		if (cap < 1)
			cap = 1;
		if (cap > CapMax)
			cap = CapMax;
		if (shadow_count >= cap && shadow_count > 0)
			burst = {burst, heap_pop()};
		tag = shadow_run_tag;
		if (shadow_emitted && it.value < shadow_last_key)
			tag = ~tag;
		heap_insert(it.value, tag);
		if (it.last_item) begin
			while (shadow_count > 0)
				burst = {burst, heap_pop()};
			if (burst.size() > 0)
				burst[burst.size() - 1].stream_end = 1'b1;
			shadow_emitted = 1'b0;
			stream_count++;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].burst_last = 1'b1;
		pending_keys = {pending_keys, burst};
	endfunction

	// predict on every accepted input beat
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sort_step(in_data);
			item_count++;
		end
	end

	// compare each output beat with the oldest pending key
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			key_count++;
			if (pending_keys.size() == 0) begin
				error_count++;
				$display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
			end else begin
				want = pending_keys.pop_front();
				if (out_data.value_res !== want.value_res) begin
					error_count++;
					$display("%0t: value_res expected %0d actual %0d", $time,
						want.value_res, out_data.value_res);
				end
				if (out_data.run_start !== want.run_start) begin
					error_count++;
					$display("%0t: run_start expected %b actual %b", $time,
						want.run_start, out_data.run_start);
				end
				if (out_data.stream_end !== want.stream_end) begin
					error_count++;
					$display("%0t: stream_end expected %b actual %b", $time,
						want.stream_end, out_data.stream_end);
				end
				if (out_data.burst_last !== want.burst_last) begin
					error_count++;
					$display("%0t: burst_last expected %b actual %b", $time,
						want.burst_last, out_data.burst_last);
				end
			end
		end
	end

	// receiver stall pattern; hold_sink forces a long hold-off
	always @(posedge clk) begin
		if (hold_sink)
			out_stall <= 1'b1;
		else if (sink_noise)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= 1'b0;
	end

	// offer one beat, hold it until taken, then drop valid
	task automatic send_key(logic signed [31:0] key, logic last);
		in_data.value <= key;
		in_data.last_item <= last;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_key();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 40) - 20;
			1:       return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $urandom;
		endcase
	endfunction

	// sender in bursts with random gaps
	task automatic send_random(int n, int last_pct);
		int burst_len;
		burst_len = 0;
		for (int i = 0; i < n; i++) begin
			if (burst_len == 0) begin
				burst_len = $urandom_range(1, 12);
				repeat ($urandom_range(0, 6))
					@(posedge clk);
			end
			burst_len--;
			send_key(random_key(), (i == n - 1) || ($urandom_range(0, 99) < last_pct));
		end
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (pending_keys.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DrainWait)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] cap);
		cfg_data <= cap;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_capacity = cap;
		@(posedge clk);
	endtask

	// extremes at reset capacity, then duplicates and run breaks at capacity 2
	task automatic test_directed();
		send_key(32'sh7fffffff, 1'b0);
		send_key(32'sh80000000, 1'b0);
		send_key(32'sh0, 1'b0);
		send_key(-32'sd1, 1'b1);
		wait_drained();
		write_capacity(5'd2);
		send_key(32'sd5, 1'b0);
		send_key(32'sd3, 1'b0);
		send_key(32'sd9, 1'b0);
		send_key(32'sd1, 1'b0);
		send_key(32'sd1, 1'b0);
		send_key(32'sd0, 1'b0);
		send_key(32'sh80000000, 1'b0);
		send_key(32'sh7fffffff, 1'b1);
		wait_drained();
		// zero acts as one
		write_capacity(5'd0);
		send_key(32'sd4, 1'b0);
		send_key(32'sd2, 1'b0);
		send_key(32'sd8, 1'b1);
		wait_drained();
	endtask

	// capacity lowered and raised between streams, including an out-of-range value
	task automatic test_capacity_change();
		write_capacity(5'd8);
		send_random(12, 0);
		wait_drained();
		write_capacity(5'd3);
		send_random(6, 0);
		wait_drained();
		write_capacity(5'd31);
		send_random(20, 0);
		wait_drained();
		write_capacity(5'd16);
		send_random(6, 0);
		send_key(32'sd0, 1'b1);
		wait_drained();
	endtask

	// long receiver hold-off so the heap backs up into the input
	task automatic test_backpressure();
		write_capacity(5'd1);
		fork
			begin
				hold_sink = 1'b1;
				repeat (300)
					@(posedge clk);
				hold_sink = 1'b0;
			end
			send_random(30, 10);
		join
		wait_drained();
	endtask

	task automatic test_random();
		logic [4:0] caps [6] = '{5'd16, 5'd1, 5'd4, 5'd7, 5'd13, 5'd16};
		foreach (caps[i]) begin
			write_capacity(caps[i]);
			sink_noise = (i % 2) == 0;
			send_random(45, 4);
			wait_drained();
		end
		sink_noise = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_sink = 1'b0;
		sink_noise = 1'b1;
		error_count = 0;
		item_count = 0;
		key_count = 0;
		run_count = 0;
		stream_count = 0;
		shadow_count = 0;
		shadow_last_key = '0;
		shadow_run_tag = 1'b0;
		shadow_emitted = 1'b0;
		shadow_capacity = 5'd16;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity_change();
		test_backpressure();
		test_random();
		wait_drained();
		$display("Sorted %0d keys from %0d inputs in %0d streams and %0d runs.",
			key_count, item_count, stream_count, run_count);
		if (error_count == 0 && pending_keys.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule

// ===== replacement_selection_run_generator_top.f =====
design/rsrg_pkg.sv
design/rsrg_datapath.sv
design/rsrg_ctrl.sv
design/replacement_selection_run_generator_top.sv
design/rsrg_checker.sv
sim/replacement_selection_run_generator_top_tb.sv
